/* design/bsc_pkg.sv */
// shared codes, command and status types for the bankers safety checker
`default_nettype none
package bsc_pkg;

  localparam int unsigned MAX_PROCESSES_DEF = 16;
  localparam int unsigned MAX_RESOURCES_DEF = 8;
  localparam int unsigned COUNT_WIDTH_DEF   = 8;

  localparam logic [2:0] MODE_LOAD_ALLOC = 3'd0;
  localparam logic [2:0] MODE_LOAD_MAX   = 3'd1;
  localparam logic [2:0] MODE_LOAD_AVAIL = 3'd2;
  localparam logic [2:0] MODE_CHECK      = 3'd3;
  localparam logic [2:0] MODE_REQUEST    = 3'd4;

  localparam logic [1:0] ST_SAFE      = 2'd0;
  localparam logic [1:0] ST_UNSAFE    = 2'd1;
  localparam logic [1:0] ST_OVER_NEED = 2'd2;
  localparam logic [1:0] ST_OVER_AVL  = 2'd3;

  localparam logic KIND_SEQ     = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  typedef struct packed {
    logic rd;
    logic cmp_fit;
    logic cmp_req;
    logic clr_flags;
    logic work_init;
    logic work_add;
    logic wr_grant;
    logic wr_back;
    logic avail_sub;
    logic avail_add;
    logic ord_wr;
    logic ord_rd;
    logic out_seq;
    logic out_verdict;
  } cmd_t;

  typedef struct packed {
    logic fits;
    logic need_bad;
    logic avail_bad;
    logic out_free;
  } stat_t;

endpackage
`default_nettype wire

/* design/bsc_datapath.sv */
// tables, vectors, compare logic and output register of the checker
`default_nettype none
module bsc_datapath #(
  parameter int unsigned MAX_PROCESSES = bsc_pkg::MAX_PROCESSES_DEF,
  parameter int unsigned MAX_RESOURCES = bsc_pkg::MAX_RESOURCES_DEF,
  parameter int unsigned COUNT_WIDTH   = bsc_pkg::COUNT_WIDTH_DEF,
  localparam int unsigned PW  = $clog2(MAX_PROCESSES),
  localparam int unsigned RW  = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1,
  localparam int unsigned RCW = $clog2(MAX_RESOURCES + 1)
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_acc_i,
  input  wire  [2:0]          mode_i,
  input  wire  [3:0]          proc_i,
  input  wire  [2:0]          res_i,
  input  wire  [7:0]          amount_i,
  input  wire  [RCW-1:0]      nr_i,
  input  bsc_pkg::cmd_t       cmd_i,
  input  wire  [PW-1:0]       mp_i,
  input  wire  [RW-1:0]       mr_i,
  input  wire  [PW-1:0]       ord_idx_i,
  input  wire  [1:0]          code_i,
  output bsc_pkg::stat_t      stat_o,
  output logic                out_valid_o,
  input  wire                 out_ready_i,
  output logic                out_kind_o,
  output logic [3:0]          out_proc_o,
  output logic [1:0]          out_status_o,
  output logic                out_last_o
);

  localparam int unsigned CW  = COUNT_WIDTH;
  localparam int unsigned WW  = COUNT_WIDTH + 5;
  localparam int unsigned XPW = (PW > 4) ? PW : 4;
  localparam int unsigned XRW = (RW > 3) ? RW : 3;
  localparam int unsigned XAW = (CW > 8) ? CW : 8;
  localparam int unsigned MD  = MAX_PROCESSES * (2 ** RW);

  logic [CW-1:0] alloc_mem [MD];
  logic [CW-1:0] max_mem   [MD];
  logic [PW-1:0] ord_mem   [MAX_PROCESSES];

  logic [CW-1:0] avail_q [MAX_RESOURCES];
  logic [CW-1:0] req_q   [MAX_RESOURCES];
  logic [CW-1:0] row_q   [MAX_RESOURCES];
  logic [CW-1:0] keep_q  [MAX_RESOURCES];
  logic [CW-1:0] ksum_q  [MAX_RESOURCES];
  logic [WW-1:0] work_q  [MAX_RESOURCES];

  logic [CW-1:0] alloc_rd_q, max_rd_q;
  logic [PW-1:0] ord_q;
  logic [RW-1:0] j_q;
  logic          cmp_fit_q, cmp_req_q;
  logic          fits_q, need_bad_q, avail_bad_q;
  logic          out_valid_q;
  logic          out_kind_q, out_last_q;
  logic [3:0]    out_proc_q;
  logic [1:0]    out_status_q;

  logic [XPW-1:0] proc_x;
  logic [XRW-1:0] res_x;
  logic [XAW-1:0] amt_x;
  logic [PW-1:0]  p_idx;
  logic [RW-1:0]  r_idx;
  logic [CW-1:0]  amt;
  logic           p_ok, r_ok;

  assign proc_x = XPW'(proc_i);
  assign res_x  = XRW'(res_i);
  assign amt_x  = XAW'(amount_i);
  assign p_idx  = proc_x[PW-1:0];
  assign r_idx  = res_x[RW-1:0];
  assign amt    = amt_x[CW-1:0];
  assign p_ok   = 32'(proc_i) < MAX_PROCESSES;
  assign r_ok   = 32'(res_i) < MAX_RESOURCES;

  // allocation table write port: grant and rollback take it over loads
  logic                 a_we, m_we;
  logic [PW+RW-1:0]     a_wa, m_wa;
  logic [CW-1:0]        a_wd;

  always_comb begin
    a_we = 1'b0;
    a_wa = {p_idx, r_idx};
    a_wd = amt;
    if (cmd_i.wr_grant) begin
      a_we = 1'b1;
      a_wa = {mp_i, mr_i};
      a_wd = ksum_q[mr_i];
    end else if (cmd_i.wr_back) begin
      a_we = 1'b1;
      a_wa = {mp_i, mr_i};
      a_wd = keep_q[mr_i];
    end else if (in_acc_i && mode_i == bsc_pkg::MODE_LOAD_ALLOC && p_ok && r_ok) begin
      a_we = 1'b1;
    end
    m_we = in_acc_i && mode_i == bsc_pkg::MODE_LOAD_MAX && p_ok && r_ok;
    m_wa = {p_idx, r_idx};
  end

  always_ff @(posedge clk_i) begin
    if (a_we) alloc_mem[a_wa] <= a_wd;
    if (m_we) max_mem[m_wa] <= amt;
    if (cmd_i.rd) begin
      alloc_rd_q <= alloc_mem[{mp_i, mr_i}];
      max_rd_q   <= max_mem[{mp_i, mr_i}];
    end
    if (cmd_i.ord_wr) ord_mem[ord_idx_i] <= mp_i;
    if (cmd_i.ord_rd) ord_q <= ord_mem[ord_idx_i];
  end

  logic [CW-1:0] need;
  assign need = (max_rd_q > alloc_rd_q) ? (max_rd_q - alloc_rd_q) : '0;

  // vectors and row buffers
  always_ff @(posedge clk_i) begin
    j_q <= mr_i;
    if (cmd_i.rd) begin
    end
    if (cmp_fit_q) row_q[j_q] <= alloc_rd_q;
    if (cmp_req_q) begin
      keep_q[j_q] <= alloc_rd_q;
      ksum_q[j_q] <= alloc_rd_q + req_q[j_q];
    end
    if (in_acc_i && mode_i == bsc_pkg::MODE_REQUEST && r_ok) req_q[r_idx] <= amt;
    for (int j = 0; j < int'(MAX_RESOURCES); j++) begin
      if (cmd_i.work_init) begin
        work_q[j] <= (j < int'(nr_i)) ? WW'(avail_q[j]) : '0;
      end else if (cmd_i.work_add && j < int'(nr_i)) begin
        if ({1'b0, work_q[j]} + (WW+1)'(row_q[j]) > (WW+1)'({WW{1'b1}})) begin
          work_q[j] <= {WW{1'b1}};
        end else begin
          work_q[j] <= work_q[j] + WW'(row_q[j]);
        end
      end
      if (cmd_i.avail_sub && j < int'(nr_i)) begin
        avail_q[j] <= avail_q[j] - req_q[j];
      end else if (cmd_i.avail_add && j < int'(nr_i)) begin
        avail_q[j] <= avail_q[j] + req_q[j];
      end else if (in_acc_i && mode_i == bsc_pkg::MODE_LOAD_AVAIL && r_ok &&
                   32'(r_idx) == 32'(j)) begin
        avail_q[j] <= amt;
      end
    end
  end

  // compare flags and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmp_fit_q   <= 1'b0;
      cmp_req_q   <= 1'b0;
      fits_q      <= 1'b1;
      need_bad_q  <= 1'b0;
      avail_bad_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cmp_fit_q <= cmd_i.rd && cmd_i.cmp_fit;
      cmp_req_q <= cmd_i.rd && cmd_i.cmp_req;
      if (cmd_i.clr_flags) begin
        fits_q      <= 1'b1;
        need_bad_q  <= 1'b0;
        avail_bad_q <= 1'b0;
      end else begin
        if (cmp_fit_q && WW'(need) > work_q[j_q]) fits_q <= 1'b0;
        if (cmp_req_q && req_q[j_q] > need) need_bad_q <= 1'b1;
        if (cmp_req_q && req_q[j_q] > avail_q[j_q]) avail_bad_q <= 1'b1;
      end
      if (cmd_i.out_seq || cmd_i.out_verdict) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  logic [XPW-1:0] ord_x;
  assign ord_x = XPW'(ord_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_seq) begin
      out_kind_q   <= bsc_pkg::KIND_SEQ;
      out_proc_q   <= ord_x[3:0];
      out_status_q <= bsc_pkg::ST_SAFE;
      out_last_q   <= 1'b0;
    end else if (cmd_i.out_verdict) begin
      out_kind_q   <= bsc_pkg::KIND_VERDICT;
      out_proc_q   <= 4'd0;
      out_status_q <= code_i;
      out_last_q   <= 1'b1;
    end
  end

  assign stat_o.fits      = fits_q;
  assign stat_o.need_bad  = need_bad_q;
  assign stat_o.avail_bad = avail_bad_q;
  assign stat_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o  = out_valid_q;
  assign out_kind_o   = out_kind_q;
  assign out_proc_o   = out_proc_q;
  assign out_status_o = out_status_q;
  assign out_last_o   = out_last_q;

endmodule
`default_nettype wire

/* design/bsc_ctrl.sv */
// sequencer for loads, request checks, safety sweeps and result output
`default_nettype none
module bsc_ctrl #(
  parameter int unsigned MAX_PROCESSES = bsc_pkg::MAX_PROCESSES_DEF,
  parameter int unsigned MAX_RESOURCES = bsc_pkg::MAX_RESOURCES_DEF,
  localparam int unsigned PW  = $clog2(MAX_PROCESSES),
  localparam int unsigned PCW = $clog2(MAX_PROCESSES + 1),
  localparam int unsigned RW  = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1,
  localparam int unsigned RCW = $clog2(MAX_RESOURCES + 1)
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_acc_i,
  input  wire  [2:0]          mode_i,
  input  wire  [3:0]          proc_i,
  input  wire                 last_i,
  input  wire  [PCW-1:0]      np_i,
  input  wire  [RCW-1:0]      nr_i,
  input  bsc_pkg::stat_t      stat_i,
  output bsc_pkg::cmd_t       cmd_o,
  output logic [PW-1:0]       mp_o,
  output logic [RW-1:0]       mr_o,
  output logic [PW-1:0]       ord_idx_o,
  output logic [1:0]          code_o,
  output logic                in_ready_o
);

  localparam int unsigned XPW = (PW > 4) ? PW : 4;

  typedef enum logic [3:0] {
    IDLE, RQ_RD, RQ_WAIT, RQ_CHK, RQ_GRANT,
    SC_INIT, SC_PROC, SC_RD, SC_WAIT, SC_CHK, SC_DONE,
    EM_RD, EM_OUT, VERDICT, RB
  } state_e;

  state_e               state_q, state_d;
  logic [PW-1:0]        i_q, i_d, p_q, p_d, e_q, e_d;
  logic [RW-1:0]        j_q, j_d;
  logic [PCW-1:0]       cnt_q, cnt_d;
  logic                 prog_q, prog_d, rq_q, rq_d;
  logic [MAX_PROCESSES-1:0] fin_q, fin_d;
  logic [1:0]           stat_q, stat_d;

  logic [XPW-1:0] proc_x;
  logic           j_last, i_last, adv;

  assign proc_x = XPW'(proc_i);
  assign j_last = 32'(j_q) == 32'(nr_i) - 32'd1;
  assign i_last = 32'(i_q) == 32'(np_i) - 32'd1;

  always_comb begin
    state_d = state_q;
    i_d = i_q; p_d = p_q; e_d = e_q; j_d = j_q;
    cnt_d = cnt_q; prog_d = prog_q; rq_d = rq_q; fin_d = fin_q; stat_d = stat_q;
    cmd_o = '0;
    adv = 1'b0;
    in_ready_o = 1'b0;
    mp_o = (state_q == SC_RD || state_q == SC_CHK) ? i_q : p_q;
    mr_o = j_q;
    ord_idx_o = (state_q == SC_CHK) ? cnt_q[PW-1:0] : e_q;
    code_o = stat_q;
    unique case (state_q)
      IDLE: begin
        in_ready_o = 1'b1;
        if (in_acc_i) begin
          p_d = proc_x[PW-1:0];
          unique case (mode_i)
            bsc_pkg::MODE_CHECK: begin
              rq_d    = 1'b0;
              state_d = SC_INIT;
            end
            bsc_pkg::MODE_REQUEST: begin
              if (last_i) begin
                if (32'(proc_i) >= 32'(np_i)) begin
                  stat_d  = bsc_pkg::ST_OVER_NEED;
                  rq_d    = 1'b0;
                  state_d = VERDICT;
                end else begin
                  j_d = '0;
                  cmd_o.clr_flags = 1'b1;
                  state_d = RQ_RD;
                end
              end
            end
            default: ;
          endcase
        end
      end
      RQ_RD: begin
        cmd_o.rd = 1'b1;
        cmd_o.cmp_req = 1'b1;
        if (j_last) state_d = RQ_WAIT;
        else j_d = j_q + 1'b1;
      end
      RQ_WAIT: state_d = RQ_CHK;
      RQ_CHK: begin
        rq_d = 1'b0;
        if (stat_i.need_bad) begin
          stat_d  = bsc_pkg::ST_OVER_NEED;
          state_d = VERDICT;
        end else if (stat_i.avail_bad) begin
          stat_d  = bsc_pkg::ST_OVER_AVL;
          state_d = VERDICT;
        end else begin
          rq_d    = 1'b1;
          j_d     = '0;
          state_d = RQ_GRANT;
        end
      end
      RQ_GRANT: begin
        cmd_o.wr_grant = 1'b1;
        cmd_o.avail_sub = (j_q == '0);
        if (j_last) state_d = SC_INIT;
        else j_d = j_q + 1'b1;
      end
      SC_INIT: begin
        cmd_o.work_init = 1'b1;
        i_d = '0; cnt_d = '0; prog_d = 1'b0; fin_d = '0;
        state_d = SC_PROC;
      end
      SC_PROC: begin
        if (fin_q[i_q]) begin
          adv = 1'b1;
        end else begin
          j_d = '0;
          cmd_o.clr_flags = 1'b1;
          state_d = SC_RD;
        end
      end
      SC_RD: begin
        cmd_o.rd = 1'b1;
        cmd_o.cmp_fit = 1'b1;
        if (j_last) state_d = SC_WAIT;
        else j_d = j_q + 1'b1;
      end
      SC_WAIT: state_d = SC_CHK;
      SC_CHK: begin
        if (stat_i.fits) begin
          cmd_o.work_add = 1'b1;
          cmd_o.ord_wr = 1'b1;
          fin_d[i_q] = 1'b1;
          cnt_d = cnt_q + 1'b1;
          prog_d = 1'b1;
        end
        adv = 1'b1;
      end
      SC_DONE: begin
        e_d = '0;
        if (cnt_q == np_i) begin
          stat_d  = bsc_pkg::ST_SAFE;
          state_d = EM_RD;
        end else begin
          stat_d  = bsc_pkg::ST_UNSAFE;
          state_d = VERDICT;
        end
      end
      EM_RD: begin
        cmd_o.ord_rd = 1'b1;
        state_d = EM_OUT;
      end
      EM_OUT: begin
        if (stat_i.out_free) begin
          cmd_o.out_seq = 1'b1;
          if (32'(e_q) == 32'(cnt_q) - 32'd1) begin
            state_d = VERDICT;
          end else begin
            e_d = e_q + 1'b1;
            state_d = EM_RD;
          end
        end
      end
      VERDICT: begin
        if (stat_i.out_free) begin
          cmd_o.out_verdict = 1'b1;
          if (rq_q && stat_q == bsc_pkg::ST_UNSAFE) begin
            j_d = '0;
            state_d = RB;
          end else begin
            state_d = IDLE;
          end
        end
      end
      RB: begin
        cmd_o.wr_back = 1'b1;
        cmd_o.avail_add = (j_q == '0);
        if (j_last) state_d = IDLE;
        else j_d = j_q + 1'b1;
      end
      default: state_d = IDLE;
    endcase
    // step to the next process; after the last one, start another sweep or end the check
    if (adv) begin
      if (i_last) begin
        if (cnt_d == np_i || !prog_d) begin
          state_d = SC_DONE;
        end else begin
          i_d = '0;
          prog_d = 1'b0;
          state_d = SC_PROC;
        end
      end else begin
        i_d = i_q + 1'b1;
        state_d = SC_PROC;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= IDLE;
      i_q <= '0; p_q <= '0; e_q <= '0; j_q <= '0;
      cnt_q <= '0; prog_q <= 1'b0; rq_q <= 1'b0; fin_q <= '0;
      stat_q <= bsc_pkg::ST_SAFE;
    end else begin
      state_q <= state_d;
      i_q <= i_d; p_q <= p_d; e_q <= e_d; j_q <= j_d;
      cnt_q <= cnt_d; prog_q <= prog_d; rq_q <= rq_d; fin_q <= fin_d;
      stat_q <= stat_d;
    end
  end

endmodule
`default_nettype wire

/* design/bankers_safety_check.sv */
// top level: configuration registers, stream ports, sequencer and datapath
//
// Bankers algorithm safety checker. Load items (allocation, maximum,
// available) are taken while the sequencer is idle and give no result. A
// safety check reads the allocation and maximum tables one resource element
// per cycle through a single read port, visiting each unfinished process in
// turn over at most np sweeps of np processes (a sweep that finishes nobody
// ends the test). It first sets up the work vector and, after the sweeps,
// decides the verdict; a safe state then gives its finishing-order entries
// and the verdict, an unsafe one the verdict only. A request adds a check
// against need and availability, a grant written resource by resource and,
// if the state is unsafe, a rollback after the verdict. New items are taken
// only while the sequencer is idle; the last result may still sit in the
// output register then.
`default_nettype none
module bankers_safety_check #(
  parameter int unsigned MAX_PROCESSES = bsc_pkg::MAX_PROCESSES_DEF,
  parameter int unsigned MAX_RESOURCES = bsc_pkg::MAX_RESOURCES_DEF,
  parameter int unsigned COUNT_WIDTH   = bsc_pkg::COUNT_WIDTH_DEF
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [2:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [15:0] s_axis_tdata,   // process[3:0], resource[6:4], amount[14:7], zero
  input  wire  [2:0]  s_axis_tuser,   // mode[2:0]
  input  wire         s_axis_tlast,   // last
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // process_res[3:0], status[5:4], zero
  output logic [0:0]  m_axis_tuser,   // kind[0]
  output logic        m_axis_tlast    // last_res
);

  localparam int unsigned PW  = $clog2(MAX_PROCESSES);
  localparam int unsigned PCW = $clog2(MAX_PROCESSES + 1);
  localparam int unsigned RW  = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1;
  localparam int unsigned RCW = $clog2(MAX_RESOURCES + 1);
  localparam logic REG_NUM_PROC = 1'b0;
  localparam logic REG_NUM_RES  = 1'b1;

  logic [4:0] num_proc_q;
  logic [3:0] num_res_q;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_proc_q <= 5'd1;
      num_res_q  <= 4'd1;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_NUM_PROC: num_proc_q <= pwdata[4:0];
        REG_NUM_RES:  num_res_q  <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_NUM_PROC: prdata = 32'(num_proc_q);
      REG_NUM_RES:  prdata = 32'(num_res_q);
      default:      prdata = '0;
    endcase
  end

  // out-of-range counts act as the nearest legal value
  logic [PCW-1:0] np;
  logic [RCW-1:0] nr;
  assign np = (num_proc_q == '0) ? PCW'(1) :
              (32'(num_proc_q) > MAX_PROCESSES) ? PCW'(MAX_PROCESSES) : PCW'(num_proc_q);
  assign nr = (num_res_q == '0) ? RCW'(1) :
              (32'(num_res_q) > MAX_RESOURCES) ? RCW'(MAX_RESOURCES) : RCW'(num_res_q);

  bsc_pkg::cmd_t  cmd;
  bsc_pkg::stat_t stat;
  logic [PW-1:0]  mp, ord_idx;
  logic [RW-1:0]  mr;
  logic [1:0]     code;
  logic           in_acc;
  logic           out_kind, out_last;
  logic [3:0]     out_proc;
  logic [1:0]     out_status;

  assign in_acc = s_axis_tvalid && s_axis_tready;

  bsc_ctrl #(
    .MAX_PROCESSES(MAX_PROCESSES),
    .MAX_RESOURCES(MAX_RESOURCES)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_acc_i   (in_acc),
    .mode_i     (s_axis_tuser),
    .proc_i     (s_axis_tdata[3:0]),
    .last_i     (s_axis_tlast),
    .np_i       (np),
    .nr_i       (nr),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .mp_o       (mp),
    .mr_o       (mr),
    .ord_idx_o  (ord_idx),
    .code_o     (code),
    .in_ready_o (s_axis_tready)
  );

  bsc_datapath #(
    .MAX_PROCESSES(MAX_PROCESSES),
    .MAX_RESOURCES(MAX_RESOURCES),
    .COUNT_WIDTH  (COUNT_WIDTH)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_acc_i     (in_acc),
    .mode_i       (s_axis_tuser),
    .proc_i       (s_axis_tdata[3:0]),
    .res_i        (s_axis_tdata[6:4]),
    .amount_i     (s_axis_tdata[14:7]),
    .nr_i         (nr),
    .cmd_i        (cmd),
    .mp_i         (mp),
    .mr_i         (mr),
    .ord_idx_i    (ord_idx),
    .code_i       (code),
    .stat_o       (stat),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_kind_o   (out_kind),
    .out_proc_o   (out_proc),
    .out_status_o (out_status),
    .out_last_o   (out_last)
  );

  assign m_axis_tdata = {2'b00, out_status, out_proc};
  assign m_axis_tuser = out_kind;
  assign m_axis_tlast = out_last;

endmodule
`default_nettype wire

/* tb/bankers_safety_check_tb.sv */
// testbench for the bankers safety checker: directed and random items, scoreboard check
`timescale 1ns / 100ps
`default_nettype none
module bankers_safety_check_tb;

  localparam int NP = 16;
  localparam int NR = 8;
  localparam int WORK_SAT = (1 << 13) - 1;
  localparam logic [2:0] ADDR_NPROC = 3'd0;
  localparam logic [2:0] ADDR_NRES  = 3'd4;

  typedef struct packed {
    logic       kind;
    logic [3:0] proc;
    logic [1:0] status;
    logic       lst;
  } verdict_t;

  class alloc_scoreboard;
    int unsigned alloc_tab[NP][NR];
    int unsigned max_tab[NP][NR];
    int unsigned avail[NR];
    int unsigned req_buf[NR];
    int unsigned n_proc = 1;
    int unsigned n_res = 1;
    verdict_t pending[$];
    int errors = 0;
    int verdicts = 0;

    function void clear();
      foreach (alloc_tab[p, r]) begin
        alloc_tab[p][r] = 0;
        max_tab[p][r] = 0;
      end
      foreach (avail[r]) begin
        avail[r] = 0;
        req_buf[r] = 0;
      end
    endfunction

    function void set_reg(int idx, int unsigned v);
      int unsigned x;
      if (idx == 0) begin
        x = v & 31;
        n_proc = (x == 0) ? 1 : (x > NP) ? NP : x;
      end else begin
        x = v & 15;
        n_res = (x == 0) ? 1 : (x > NR) ? NR : x;
      end
    endfunction

    function int unsigned need(int p, int r);
      return (max_tab[p][r] > alloc_tab[p][r]) ? max_tab[p][r] - alloc_tab[p][r] : 0;
    endfunction

    // runs the safety sweep and queues the order and verdict, returns 1 if safe
    function bit run_safety();
      int unsigned work[NR];
      bit [15:0] done;
      int order[$];
      bit fits;
      verdict_t v;
      done = '0;
      for (int j = 0; j < NR; j++) work[j] = (j < n_res) ? avail[j] : 0;
      for (int k = 0; k < n_proc; k++)
        for (int i = 0; i < n_proc; i++) begin
          if (done[i]) continue;
          fits = 1;
          for (int j = 0; j < n_res; j++) if (need(i, j) > work[j]) fits = 0;
          if (!fits) continue;
          for (int j = 0; j < n_res; j++) begin
            work[j] = work[j] + alloc_tab[i][j];
            if (work[j] > WORK_SAT) work[j] = WORK_SAT;
          end
          done[i] = 1;
          order.push_back(i);
        end
      if (order.size() == n_proc)
        foreach (order[i]) begin
          v = '{bsc_pkg::KIND_SEQ, order[i][3:0], bsc_pkg::ST_SAFE, 1'b0};
          pending.push_back(v);
        end
      v = '{bsc_pkg::KIND_VERDICT, 4'd0,
            (order.size() == n_proc) ? bsc_pkg::ST_SAFE : bsc_pkg::ST_UNSAFE, 1'b1};
      pending.push_back(v);
      return order.size() == n_proc;
    endfunction

    function void note_request(logic [2:0] mode, int p, int r, int unsigned amt, bit lst);
      logic [1:0] code;
      verdict_t v;
      case (mode)
        bsc_pkg::MODE_LOAD_ALLOC: alloc_tab[p][r] = amt;
        bsc_pkg::MODE_LOAD_MAX:   max_tab[p][r] = amt;
        bsc_pkg::MODE_LOAD_AVAIL: avail[r] = amt;
        bsc_pkg::MODE_CHECK:      void'(run_safety());
        bsc_pkg::MODE_REQUEST: begin
          req_buf[r] = amt;
          if (lst) begin
            code = bsc_pkg::ST_SAFE;
            if (p >= n_proc) code = bsc_pkg::ST_OVER_NEED;
            else begin
              for (int j = 0; j < n_res; j++)
                if (req_buf[j] > need(p, j)) code = bsc_pkg::ST_OVER_NEED;
              if (code == bsc_pkg::ST_SAFE)
                for (int j = 0; j < n_res; j++)
                  if (req_buf[j] > avail[j]) code = bsc_pkg::ST_OVER_AVL;
            end
            if (code != bsc_pkg::ST_SAFE) begin
              v = '{bsc_pkg::KIND_VERDICT, 4'd0, code, 1'b1};
              pending.push_back(v);
            end else begin
              for (int j = 0; j < n_res; j++) begin
                avail[j] -= req_buf[j];
                alloc_tab[p][j] = (alloc_tab[p][j] + req_buf[j]) & 255;
              end
              if (!run_safety())
                for (int j = 0; j < n_res; j++) begin
                  avail[j] += req_buf[j];
                  alloc_tab[p][j] = (alloc_tab[p][j] - req_buf[j]) & 255;
                end
            end
          end
        end
        default: ;
      endcase
    endfunction

    function void check_result(verdict_t got);
      verdict_t e;
      if (pending.size() == 0) begin
        $error("unexpected result kind=%0d proc=%0d status=%0d", got.kind, got.proc, got.status);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.kind == bsc_pkg::KIND_VERDICT) verdicts++;
      if (got.kind !== e.kind) begin
        $error("kind expected %0d actual %0d", e.kind, got.kind); errors++;
      end
      if (got.proc !== e.proc) begin
        $error("process_res expected %0d actual %0d", e.proc, got.proc); errors++;
      end
      if (got.status !== e.status) begin
        $error("status expected %0d actual %0d", e.status, got.status); errors++;
      end
      if (got.lst !== e.lst) begin
        $error("last_res expected %0d actual %0d", e.lst, got.lst); errors++;
      end
    endfunction
  endclass

  logic clk_i = 0, rst_ni = 0;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  wire [31:0] prdata;
  wire pready;
  logic s_valid = 0, s_last = 0;
  logic [15:0] s_data = '0;
  logic [2:0] s_user = '0;
  wire s_ready, m_valid, m_last;
  wire [7:0] m_data;
  wire [0:0] m_user;
  logic m_ready = 0;
  bit quiet = 0;
  alloc_scoreboard sb;

  always #1 clk_i = ~clk_i;

  bankers_safety_check u_dut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .s_axis_tvalid(s_valid), .s_axis_tready(s_ready), .s_axis_tdata(s_data),
    .s_axis_tuser(s_user), .s_axis_tlast(s_last),
    .m_axis_tvalid(m_valid), .m_axis_tready(m_ready), .m_axis_tdata(m_data),
    .m_axis_tuser(m_user), .m_axis_tlast(m_last)
  );

  always @(posedge clk_i)
    if (rst_ni && m_valid && m_ready)
      sb.check_result(verdict_t'{m_user[0], m_data[3:0], m_data[5:4], m_last});

  // receiver stalls in bursts
  always @(negedge clk_i) begin
    if (quiet || !rst_ni) m_ready <= rst_ni;
    else if ($urandom_range(0, 3) == 0) begin
      m_ready <= 0;
      repeat ($urandom_range(1, 6) - 1) @(negedge clk_i);
    end else m_ready <= 1;
  end

  task automatic write_reg(int idx, int unsigned v);
    @(negedge clk_i);
    s_valid <= 0;
    psel <= 1; pwrite <= 1; penable <= 0;
    paddr <= (idx == 0) ? ADDR_NPROC : ADDR_NRES; pwdata <= v;
    @(negedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    sb.set_reg(idx, v);
    @(negedge clk_i);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  task automatic send(logic [2:0] mode, int p, int r, int unsigned amt, bit lst);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      @(negedge clk_i);
      s_valid <= 0;
      repeat ($urandom_range(1, 6) - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_valid <= 1; s_user <= mode; s_last <= lst;
    s_data <= {1'b0, amt[7:0], r[2:0], p[3:0]};
    do @(posedge clk_i); while (!s_ready);
    // the block sees only the field bits
    sb.note_request(mode, p & 15, r & 7, amt & 255, lst);
  endtask

  task automatic drain();
    int guard = 0;
    @(negedge clk_i);
    s_valid <= 0;
    while (sb.pending.size() != 0 && guard < 200000) begin
      @(negedge clk_i); guard++;
    end
    repeat (40) @(negedge clk_i);
  endtask

  // fills tables for the first np x nr entries and the first nr available counts
  task automatic load_state(int np, int nr, bit generous);
    for (int p = 0; p < np; p++)
      for (int r = 0; r < nr; r++) begin
        send(bsc_pkg::MODE_LOAD_ALLOC, p, r, $urandom_range(0, generous ? 10 : 255), 0);
        send(bsc_pkg::MODE_LOAD_MAX, p, r, $urandom_range(0, generous ? 30 : 255), 0);
      end
    for (int r = 0; r < nr; r++)
      send(bsc_pkg::MODE_LOAD_AVAIL, 0, r,
           generous ? $urandom_range(5, 40) : $urandom_range(0, 255), 0);
  endtask

  // fill the whole store once so every read is defined
  task automatic load_all();
    for (int p = 0; p < NP; p++)
      for (int r = 0; r < NR; r++) begin
        send(bsc_pkg::MODE_LOAD_ALLOC, p, r, 0, 0);
        send(bsc_pkg::MODE_LOAD_MAX, p, r, 0, 0);
      end
    for (int r = 0; r < NR; r++) begin
      send(bsc_pkg::MODE_LOAD_AVAIL, 0, r, 0, 0);
      send(bsc_pkg::MODE_REQUEST, 0, r, 0, 0);
    end
  endtask

  task automatic send_request(int p, int nr, int hi);
    for (int r = 0; r < nr; r++)
      send(bsc_pkg::MODE_REQUEST, p, r, $urandom_range(0, hi), r == nr - 1);
  endtask

  initial begin
    int np, nr, count;
    sb = new();
    sb.clear();
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1;
    load_all();
    // directed: extremes, every mode, special cases
    write_reg(0, 16); write_reg(1, 8);
    send(bsc_pkg::MODE_CHECK, 0, 0, 0, 0);
    send(bsc_pkg::MODE_LOAD_ALLOC, 15, 7, 255, 0);
    send(bsc_pkg::MODE_LOAD_MAX, 15, 7, 255, 0);
    send(bsc_pkg::MODE_LOAD_AVAIL, 0, 7, 255, 0);
    send(bsc_pkg::MODE_LOAD_MAX, 3, 2, 200, 0);
    send(bsc_pkg::MODE_CHECK, 0, 0, 0, 0);
    send(3'd5, 9, 5, 170, 1);
    send(3'd6, 6, 2, 85, 0);
    send(3'd7, 15, 7, 255, 1);
    send(bsc_pkg::MODE_REQUEST, 3, 2, 255, 1);       // above need
    send(bsc_pkg::MODE_REQUEST, 3, 2, 100, 1);       // above available
    send(bsc_pkg::MODE_LOAD_AVAIL, 0, 2, 150, 0);
    send(bsc_pkg::MODE_REQUEST, 3, 2, 100, 1);       // passes the checks, found unsafe, rolled back
    send(bsc_pkg::MODE_REQUEST, 3, 2, 0, 0);
    send(bsc_pkg::MODE_REQUEST, 3, 2, 0, 1);
    drain();
    write_reg(0, 20); write_reg(1, 0);     // out-of-range register values
    send(bsc_pkg::MODE_REQUEST, 17, 0, 0, 1);
    send(bsc_pkg::MODE_REQUEST, 15, 0, 0, 1);
    send(bsc_pkg::MODE_CHECK, 0, 0, 0, 0);
    drain();
    write_reg(0, 0); write_reg(1, 15);
    send(bsc_pkg::MODE_CHECK, 0, 0, 0, 0);
    send(bsc_pkg::MODE_REQUEST, 1, 0, 0, 1);         // process not in use
    drain();
    // random phases
    count = 0;
    while (count < 140) begin
      if (count > 100) quiet = 1;
      np = ($urandom_range(0, 5) == 0) ? 16 : $urandom_range(1, 6);
      nr = ($urandom_range(0, 5) == 0) ? 8 : $urandom_range(1, 4);
      if ($urandom_range(0, 7) == 0) np = 1;
      write_reg(0, np); write_reg(1, nr);
      load_state(np, nr, $urandom_range(0, 3) != 0);
      count += 2 * np * nr + nr;
      repeat ($urandom_range(2, 5)) begin
        case ($urandom_range(0, 5))
          0: send(bsc_pkg::MODE_CHECK, 0, 0, 0, 0);
          1: send($urandom_range(0, 7), $urandom_range(0, 15), $urandom_range(0, 7),
                  $urandom_range(0, 255), $urandom_range(0, 1));
          default: send_request($urandom_range(0, np), nr, $urandom_range(0, 12));
        endcase
        count += nr;
      end
      drain();
    end
    quiet = 1;
    drain();
    $display("covered %0d stimulus items over random table sizes, %0d verdicts checked",
             count, sb.verdicts);
    if (sb.errors == 0 && sb.pending.size() == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  initial begin
    #4000000;
    $display("Verification failed");
    $finish;
  end
endmodule
`default_nettype wire

/* bankers_safety_check.f */
design/bsc_pkg.sv
design/bsc_datapath.sv
design/bsc_ctrl.sv
design/bankers_safety_check.sv
tb/bankers_safety_check_tb.sv
